/* design/huffman_tree_walk_decoder_unit_defines.svh */
// ----------------------------------------------------------------------------
// huffman tree walk decoder - assertion macros
// wraps concurrent assertions so they can be compiled out
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_UNIT_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HTW_ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("htw: forbidden condition seen");
`define HTW_ASSERT_IMPLY(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("htw: implication failed");
`else
`define HTW_ASSERT_NEVER(name, clk, rst, cond)
`define HTW_ASSERT_IMPLY(name, clk, rst, pre, post)
`endif

`endif

/* design/htw_pkg.sv */
// ----------------------------------------------------------------------------
// htw_pkg
// shared types and constants of the huffman tree walk decoder
// ----------------------------------------------------------------------------
`default_nettype none

package htw_pkg;

  localparam int NODE_COUNT_DEFAULT = 256;
  localparam int IDX_W = 8;
  localparam int SYM_W = 8;
  localparam int CODE_W = 8;
  localparam int CODE_MSB = CODE_W - 1;
  localparam int OP_W = 2;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] sym;
  } node_t;

  typedef struct packed {
    logic [OP_W-1:0]   kind;
    logic [IDX_W-1:0]  addr;
    node_t             node;
    logic [CODE_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

/* design/huffman_tree_walk_decoder_unit.sv */
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_unit
// loads a code tree into a node store and walks it bit by bit, msb first
// ----------------------------------------------------------------------------
// channel   direction  handshake                       payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata, tuser (opcode)
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata (symbol), tlast
// cfg       in         cfg_valid / cfg_ready           cfg_data (root_node)
//
// a node write or restart is handled in the idle state of the walk engine
// a decode byte walks its bits one at a time, paced by the single read port
// of the node store (one node read per step)
// a two entry command queue lets input transactions land while a byte decodes
// reset clears walk state to the root and empties queue and output register
// a stalled output holds the engine only when a held symbol must move into it
// ----------------------------------------------------------------------------
`default_nettype none
`include "huffman_tree_walk_decoder_unit_defines.svh"

module huffman_tree_walk_decoder_unit #(
  parameter int NODE_COUNT = htw_pkg::NODE_COUNT_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // node_addr[7:0], node_leaf[8], left_child[16:9], right_child[24:17],
  // leaf_symbol[32:25], code_byte[40:33], zero pad[47:41]
  input  wire logic [htw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode[1:0]
  input  wire logic [htw_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // symbol[7:0]
  output logic [htw_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  output logic                                    m_axis_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [htw_pkg::IDX_W-1:0]          cfg_data
);
  import htw_pkg::*;

  cmd_t             head;
  q_status_t        q_status;
  logic             pop;
  logic [IDX_W-1:0] root_node;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_node <= cfg_data;
    end
  end

  htw_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop           (pop),
    .head          (head),
    .q_status      (q_status)
  );

  htw_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .root_node     (root_node),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `HTW_ASSERT_NEVER(a_pop_empty, clk, rst, pop && q_status.empty)
  `HTW_ASSERT_NEVER(a_queue_state, clk, rst, q_status.empty && q_status.full)
  `HTW_ASSERT_IMPLY(a_out_idle_after_rst, clk, rst, $past(rst), !m_axis_tvalid)

endmodule

`default_nettype wire

/* design/htw_front.sv */
// ----------------------------------------------------------------------------
// htw_front
// accepts input transactions, drops unused opcodes, queues commands
// ----------------------------------------------------------------------------
`default_nettype none

module htw_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [htw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  wire logic [htw_pkg::OP_W-1:0]           s_axis_tuser,
  input  wire logic                               pop,
  output htw_pkg::cmd_t                           head,
  output htw_pkg::q_status_t                      q_status
);
  import htw_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.kind       = s_axis_tuser;
    cmd_in.addr       = s_axis_tdata[7:0];
    cmd_in.node.leaf  = s_axis_tdata[8];
    cmd_in.node.left  = s_axis_tdata[16:9];
    cmd_in.node.right = s_axis_tdata[24:17];
    cmd_in.node.sym   = s_axis_tdata[32:25];
    cmd_in.code       = s_axis_tdata[40:33];
  end

  assign q_status.empty = (count == 2'd0);
  assign q_status.full  = (count == 2'd2);
  assign s_axis_tready  = !q_status.full;
  assign push = s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_NONE);
  assign head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/htw_back.sv */
// ----------------------------------------------------------------------------
// htw_back
// node store with a single read port and tree walk engine
// ----------------------------------------------------------------------------
`default_nettype none

module htw_back #(
  parameter int NODE_COUNT = htw_pkg::NODE_COUNT_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire htw_pkg::cmd_t                     head,
  input  wire htw_pkg::q_status_t                q_status,
  output logic                                   pop,
  input  wire logic [htw_pkg::IDX_W-1:0]         root_node,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [htw_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  output logic                                   m_axis_tlast
);
  import htw_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_CUR   = 3'd2;
  localparam logic [2:0] S_CHILD = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  node_t mem [NODE_COUNT];

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic              at_root;
  logic [IDX_W-1:0]  walk_node;
  logic              cur_valid;
  node_t             cur_data;
  logic [IDX_W-1:0]  child_reg;
  logic [CODE_W-1:0] code;
  logic [2:0]        bit_pos;
  logic              pend_valid;
  logic [SYM_W-1:0]  pend_sym;

  node_t             rd_data;
  logic              rd_oob;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;
  logic              wr_en;

  node_t             node_rd;
  node_t             node;
  logic [IDX_W-1:0]  cur_idx;
  logic [IDX_W-1:0]  child_idx;
  logic              out_free;
  logic              emit_ok;
  logic              emit;
  logic [SYM_W-1:0]  emit_sym;
  logic              bit_done;
  logic              advance;
  logic              flush_push;

  assign node_rd   = rd_oob ? '0 : rd_data;
  assign node      = cur_valid ? cur_data : node_rd;
  assign cur_idx   = at_root ? root_node : walk_node;
  assign child_idx = code[CODE_MSB] ? node.right : node.left;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign emit_ok   = !pend_valid || out_free;

  // node store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(head.addr)] <= head.node;
    end
    if (rd_en) begin
      rd_data <= mem[AW'(rd_idx)];
      rd_oob  <= !(32'(rd_idx) < NODE_COUNT);
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_idx     = cur_idx;
    emit       = 1'b0;
    emit_sym   = node.sym;
    bit_done   = 1'b0;
    advance    = 1'b0;
    flush_push = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          if (head.kind == OP_WRITE) begin
            wr_en = (32'(head.addr) < NODE_COUNT);
          end else if (head.kind == OP_DECODE) begin
            state_next = cur_valid ? S_CUR : S_LOOK;
          end
        end
      end
      S_LOOK: begin
        rd_en      = 1'b1;
        rd_idx     = cur_idx;
        state_next = S_CUR;
      end
      S_CUR: begin
        if (node.leaf) begin
          if (emit_ok) begin
            emit     = 1'b1;
            emit_sym = node.sym;
            bit_done = 1'b1;
          end
        end else begin
          rd_en      = 1'b1;
          rd_idx     = child_idx;
          state_next = S_CHILD;
        end
      end
      S_CHILD: begin
        if (node_rd.leaf) begin
          if (emit_ok) begin
            emit     = 1'b1;
            emit_sym = node_rd.sym;
            bit_done = 1'b1;
          end
        end else begin
          advance  = 1'b1;
          bit_done = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          flush_push = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (bit_done) begin
      if (bit_pos == 3'd0) begin
        state_next = S_FLUSH;
      end else begin
        state_next = advance ? S_CUR : S_LOOK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CUR && !node.leaf) begin
      child_reg <= child_idx;
    end
    if (advance) begin
      cur_data <= node_rd;
    end
    if (pop && head.kind == OP_DECODE) begin
      code    <= head.code;
      bit_pos <= 3'(CODE_MSB);
    end else if (bit_done) begin
      code    <= code << 1;
      bit_pos <= bit_pos - 3'd1;
    end
    if (emit) begin
      pend_sym <= emit_sym;
    end
    if (emit && pend_valid) begin
      m_axis_tdata <= pend_sym;
      m_axis_tlast <= 1'b0;
    end else if (flush_push) begin
      m_axis_tdata <= pend_sym;
      m_axis_tlast <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      at_root       <= 1'b1;
      walk_node     <= '0;
      cur_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (flush_push || (emit && pend_valid)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (pop && head.kind == OP_WRITE) begin
        cur_valid <= 1'b0;
      end
      if (pop && head.kind == OP_RESTART) begin
        at_root   <= 1'b1;
        cur_valid <= 1'b0;
      end
      if (emit) begin
        at_root    <= 1'b1;
        cur_valid  <= 1'b0;
        pend_valid <= 1'b1;
      end
      if (advance) begin
        walk_node <= child_reg;
        at_root   <= 1'b0;
        cur_valid <= 1'b1;
      end
      if (flush_push) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
